@@ rtl/ccl_pkg.sv @@
// ============================================================================
// ccl_pkg
// Shared types and constants for the chunk cache LRU lookup block.
// ============================================================================
package ccl_pkg;

  // Default sizing
  localparam int DEF_CACHE_SLOTS = 32;
  localparam int DEF_COORD_BITS  = 24;

  // Fixed field widths on the stream ports
  localparam int FIELD_BITS  = 24;
  localparam int SLOT_BITS   = 5;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 80;

  // Result status codes
  typedef enum logic [1:0] {
    ST_HIT    = 2'd0,
    ST_MISS   = 2'd1,
    ST_ABSENT = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic start;   // latch request, clear scan trackers
    logic scan;    // scan pass in progress
    logic commit;  // apply update and load the result register
  } ccl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;  // last slot has been compared
    logic out_free;   // result register can take a new item
  } ccl_stat_t;

endpackage

@@ rtl/ccl_ctrl.sv @@
// ============================================================================
// ccl_ctrl
// Sequencer: accept a request, run the slot scan, then commit the update and
// the result once the result register is free.
// ============================================================================
module ccl_ctrl
  import ccl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ccl_stat_t stat,
  output ccl_cmd_t  cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_done) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready   = (state == S_IDLE);
    cmd.start  = (state == S_IDLE) && in_valid;
    cmd.scan   = (state == S_SCAN);
    cmd.commit = (state == S_COMMIT) && stat.out_free;
  end

endmodule

@@ rtl/ccl_datapath.sv @@
// ============================================================================
// ccl_datapath
// Position memory, valid bits, age counters, scan trackers and the result
// register.
// ============================================================================
module ccl_datapath
  import ccl_pkg::*;
#(
  parameter int CACHE_SLOTS = DEF_CACHE_SLOTS,
  parameter int COORD_BITS  = DEF_COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ccl_cmd_t                     cmd,
  output ccl_stat_t                    stat,
  input  logic signed [FIELD_BITS-1:0] req_x_in,
  input  logic signed [FIELD_BITS-1:0] req_y_in,
  input  logic signed [FIELD_BITS-1:0] req_z_in,
  input  logic                         req_present_in,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic [OUT_TDATA_W-1:0]       res_data
);

  localparam int IDXW = $clog2(CACHE_SLOTS);
  localparam int AGEW = IDXW;
  localparam int POSW = 3 * COORD_BITS;
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(CACHE_SLOTS - 1);

  // Latched request
  logic [POSW-1:0] req_pos;
  logic            req_present;

  // Slot state
  logic [POSW-1:0] pos_mem [CACHE_SLOTS];
  logic [POSW-1:0] rd_data;
  logic [CACHE_SLOTS-1:0] slot_valid;
  logic [AGEW-1:0] slot_age [CACHE_SLOTS];

  // Scan pipeline: read issue then compare
  logic            issue_on;
  logic [IDXW-1:0] issue_idx;
  logic            cmp_vld;
  logic [IDXW-1:0] cmp_idx;

  // Trackers
  logic            hit_found;
  logic [IDXW-1:0] hit_idx;
  logic [AGEW-1:0] hit_age;
  logic            empty_found;
  logic [IDXW-1:0] empty_idx;
  logic [IDXW-1:0] best_idx;
  logic [AGEW-1:0] best_age;
  logic [POSW-1:0] best_pos;

  // Decision
  status_t         res_status;
  logic [IDXW-1:0] target;
  logic            age_all;
  logic [AGEW-1:0] limit;
  logic            do_alloc;
  logic            evict;
  logic [POSW-1:0] ev_pos;

  logic            cmp_slot_valid;
  logic [AGEW-1:0] cmp_age;

  // Request latch; coordinates resized to the stored width
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_pos     <= {COORD_BITS'(req_z_in), COORD_BITS'(req_y_in), COORD_BITS'(req_x_in)};
      req_present <= req_present_in;
    end
  end

  // Read issue counter
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_on  <= 1'b0;
      issue_idx <= '0;
      cmp_vld   <= 1'b0;
    end else begin
      cmp_vld <= cmd.scan && issue_on;
      if (cmd.start) begin
        issue_on  <= 1'b1;
        issue_idx <= '0;
      end else if (cmd.scan && issue_on) begin
        if (issue_idx == LAST_IDX) issue_on <= 1'b0;
        else                       issue_idx <= issue_idx + 1'b1;
      end
    end
  end

  // Position memory: one read port for the scan, one write port at commit
  always_ff @(posedge clk) begin
    if (cmd.scan && issue_on) begin
      rd_data <= pos_mem[issue_idx];
      cmp_idx <= issue_idx;
    end
    if (cmd.commit && do_alloc) begin
      pos_mem[target] <= req_pos;
    end
  end

  assign cmp_slot_valid = slot_valid[cmp_idx];
  assign cmp_age        = slot_age[cmp_idx];

  // Compare stage trackers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      hit_found   <= 1'b0;
      empty_found <= 1'b0;
      hit_idx     <= '0;
      empty_idx   <= '0;
    end else if (cmp_vld) begin
      if (!hit_found && cmp_slot_valid && rd_data == req_pos) begin
        hit_found <= 1'b1;
        hit_idx   <= cmp_idx;
        hit_age   <= cmp_age;
      end
      if (!empty_found && !cmp_slot_valid) begin
        empty_found <= 1'b1;
        empty_idx   <= cmp_idx;
      end
      // oldest entry, lowest index on ties
      if (cmp_idx == '0 || cmp_age > best_age) begin
        best_idx <= cmp_idx;
        best_age <= cmp_age;
        best_pos <= rd_data;
      end
    end
  end

  // Outcome of the scan
  always_comb begin
    res_status = ST_HIT;
    target     = hit_idx;
    age_all    = 1'b0;
    limit      = hit_age;
    do_alloc   = 1'b0;
    evict      = 1'b0;
    ev_pos     = '0;
    priority if (hit_found) begin
      res_status = ST_HIT;
    end else if (!req_present) begin
      res_status = ST_ABSENT;
      target     = '0;
    end else if (empty_found) begin
      res_status = ST_MISS;
      target     = empty_idx;
      age_all    = 1'b1;
      do_alloc   = 1'b1;
    end else begin
      res_status = ST_MISS;
      target     = best_idx;
      limit      = best_age;
      do_alloc   = 1'b1;
      evict      = 1'b1;
      ev_pos     = best_pos;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (cmd.commit && do_alloc) begin
      slot_valid[target] <= 1'b1;
    end
  end

  // Age counters: younger valid entries step up, the target goes to zero
  always_ff @(posedge clk) begin
    if (cmd.commit && res_status != ST_ABSENT) begin
      for (int j = 0; j < CACHE_SLOTS; j++) begin
        if (j == int'(target)) begin
          slot_age[j] <= '0;
        end else if (slot_valid[j] && (age_all || slot_age[j] < limit)) begin
          slot_age[j] <= slot_age[j] + 1'b1;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.commit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_data <= {
        FIELD_BITS'($unsigned(ev_pos[3*COORD_BITS-1:2*COORD_BITS])),
        FIELD_BITS'($unsigned(ev_pos[2*COORD_BITS-1:COORD_BITS])),
        FIELD_BITS'($unsigned(ev_pos[COORD_BITS-1:0])),
        evict,
        SLOT_BITS'(target),
        res_status
      };
    end
  end

  assign stat.scan_done = cmp_vld && (cmp_idx == LAST_IDX);
  assign stat.out_free  = !res_valid || res_ready;

endmodule

@@ rtl/chunk_cache_lru_lookup.sv @@
// ============================================================================
// chunk_cache_lru_lookup
// Fully associative chunk position directory with age-counter LRU
// replacement: hit, allocate (first empty or oldest slot) or absent.
// ============================================================================
//  channel  dir  handshake               payload
//  s_*      in   s_tvalid / s_tready     chunk_x, chunk_y, chunk_z, present
//  m_*      out  m_tvalid / m_tready     status, slot, evicted_valid, evicted xyz
//
//  After acceptance the block reads every slot in turn, compares the last
//  entry and commits, and m_tvalid then rises. A new item is taken only
//  once the previous one has committed.
//  Reset clears the valid bits and control; positions and ages stay
//  unset until written. A stalled result holds its register and the
//  following item scans meanwhile, waiting at commit until it is taken.
// ============================================================================
module chunk_cache_lru_lookup
  import ccl_pkg::*;
#(
  parameter int CACHE_SLOTS = DEF_CACHE_SLOTS,
  parameter int COORD_BITS  = DEF_COORD_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [23:0] chunk_x, [47:24] chunk_y, [71:48] chunk_z, [72] present_in_store
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [1:0] status, [6:2] slot, [7] evicted_valid,
  // [31:8] evicted_x, [55:32] evicted_y, [79:56] evicted_z
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  ccl_cmd_t  cmd;
  ccl_stat_t stat;

  ccl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ccl_datapath #(
    .CACHE_SLOTS (CACHE_SLOTS),
    .COORD_BITS  (COORD_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .req_x_in       (s_tdata[23:0]),
    .req_y_in       (s_tdata[47:24]),
    .req_z_in       (s_tdata[71:48]),
    .req_present_in (s_tdata[72]),
    .res_valid      (m_tvalid),
    .res_ready      (m_tready),
    .res_data       (m_tdata)
  );

endmodule

@@ test/chunk_cache_lru_lookup_test.sv @@
`timescale 1ns / 100ps
// ============================================================================
// chunk_cache_lru_lookup_test
// Drives chunk position lookups into the cache directory and checks every
// result against a behavioral copy of the directory (valid bits, positions,
// LRU ages). The run opens with directed corner items, then random phases
// over working sets that give hits, near misses, allocations and evictions,
// with random idling on both streams and two long result back-pressure holds.
// ============================================================================
module chunk_cache_lru_lookup_test;
  import ccl_pkg::*;

  localparam int SLOTS        = DEF_CACHE_SLOTS;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 2 * (DEF_CACHE_SLOTS + 3);
  localparam int PHASES       = 4;
  localparam int PHASE_ITEMS  = 300;
  localparam int POOL_MAX     = 48;
  localparam int IDLE_PCT     = 28;

  typedef logic [FIELD_BITS-1:0] coord_t;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   present;
  } chunk_request_t;

  typedef struct {
    status_t              status;
    logic [SLOT_BITS-1:0] slot;
    logic                 evicted_valid;
    coord_t               ex;
    coord_t               ey;
    coord_t               ez;
  } lookup_result_t;

  // Directory copy plus the queue of results still owed by the block
  class slot_directory_tracker;
    logic                 valid [SLOTS];
    coord_t               pos_x [SLOTS];
    coord_t               pos_y [SLOTS];
    coord_t               pos_z [SLOTS];
    logic [SLOT_BITS-1:0] age   [SLOTS];
    lookup_result_t       owed_results [$];
    int                   errors;

    function new();
      int i;
      errors = 0;
      for (i = 0; i < SLOTS; i++) begin
        valid[i] = 1'b0;
        pos_x[i] = '0;
        pos_y[i] = '0;
        pos_z[i] = '0;
        age[i]   = '0;
      end
    endfunction

    // Valid entries younger than limit grow one older; slot s becomes newest
    function void refresh_ages(int s, int limit);
      int i;
      for (i = 0; i < SLOTS; i++)
        if (valid[i] && int'(age[i]) < limit) age[i] = age[i] + 1'b1;
      age[s] = '0;
    endfunction

    function lookup_result_t resolve_lookup(chunk_request_t req);
      lookup_result_t res;
      int i;
      int hit;
      int victim;
      int limit;
      res.status        = ST_HIT;
      res.slot          = '0;
      res.evicted_valid = 1'b0;
      res.ex            = '0;
      res.ey            = '0;
      res.ez            = '0;

      // lowest matching resident slot wins
      hit = -1;
      for (i = 0; i < SLOTS; i++)
        if (hit < 0 && valid[i] && pos_x[i] == req.x && pos_y[i] == req.y &&
            pos_z[i] == req.z)
          hit = i;
      if (hit >= 0) begin
        refresh_ages(hit, int'(age[hit]));
        res.slot = SLOT_BITS'(hit);
        return res;
      end

      if (!req.present) begin
        res.status = ST_ABSENT;
        return res;
      end

      // first empty slot, else oldest (lowest index on a tie)
      victim = -1;
      for (i = 0; i < SLOTS; i++)
        if (victim < 0 && !valid[i]) victim = i;
      if (victim >= 0) begin
        limit = SLOTS + 1;
      end else begin
        victim = 0;
        for (i = 1; i < SLOTS; i++)
          if (age[i] > age[victim]) victim = i;
        limit             = int'(age[victim]);
        res.evicted_valid = 1'b1;
        res.ex            = pos_x[victim];
        res.ey            = pos_y[victim];
        res.ez            = pos_z[victim];
      end

      refresh_ages(victim, limit);
      valid[victim] = 1'b1;
      pos_x[victim] = req.x;
      pos_y[victim] = req.y;
      pos_z[victim] = req.z;
      res.status    = ST_MISS;
      res.slot      = SLOT_BITS'(victim);
      return res;
    endfunction

    function void note_request(chunk_request_t req);
      owed_results.insert(owed_results.size(), resolve_lookup(req));
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] d);
      lookup_result_t want;
      if (owed_results.size() == 0) begin
        report($sformatf("result %h with nothing outstanding", d));
        return;
      end
      want = owed_results.pop_front();
      if (d[1:0] !== want.status)
        report($sformatf("status %0d, want %0d", d[1:0], want.status));
      if (d[6:2] !== want.slot)
        report($sformatf("slot %0d, want %0d", d[6:2], want.slot));
      if (d[7] !== want.evicted_valid)
        report($sformatf("evicted_valid %b, want %b", d[7], want.evicted_valid));
      if (d[31:8] !== want.ex)
        report($sformatf("evicted_x %h, want %h", d[31:8], want.ex));
      if (d[55:32] !== want.ey)
        report($sformatf("evicted_y %h, want %h", d[55:32], want.ey));
      if (d[79:56] !== want.ez)
        report($sformatf("evicted_z %h, want %h", d[79:56], want.ez));
    endtask
  endclass

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  slot_directory_tracker tracker;
  bit                    calm         = 1'b0;
  bit                    hold_request = 1'b0;

  // working set for the random phases
  coord_t pool_x [POOL_MAX];
  coord_t pool_y [POOL_MAX];
  coord_t pool_z [POOL_MAX];
  int     pool_size;

  chunk_cache_lru_lookup i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #4 clk = ~clk;

  // Watch both streams; values sampled here are the pre-edge ones
  always @(posedge clk) begin : bus_watch
    chunk_request_t seen;
    if (!rst) begin
      if (m_tvalid && m_tready) tracker.check_result(m_tdata);
      if (s_tvalid && s_tready) begin
        seen.x       = s_tdata[23:0];
        seen.y       = s_tdata[47:24];
        seen.z       = s_tdata[71:48];
        seen.present = s_tdata[72];
        tracker.note_request(seen);
      end
    end
  end

  // Result sink: random back-pressure, plus a long hold when requested
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= !rst && (calm || $urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    #4_000_000;
    $display("chunk_cache_lru_lookup_test failed");
    $finish;
  end

  function automatic chunk_request_t make_request(coord_t x, coord_t y, coord_t z,
                                                  logic present);
    chunk_request_t req;
    req.x       = x;
    req.y       = y;
    req.z       = z;
    req.present = present;
    return req;
  endfunction

  // Offer one item, with random idle cycles ahead of it
  task automatic offer_request(chunk_request_t req);
    logic [IN_TDATA_W-1:0] word;
    word        = '0;
    word[23:0]  = req.x;
    word[47:24] = req.y;
    word[71:48] = req.z;
    word[72]    = req.present;
    if (!calm)
      while ($urandom_range(99) < IDLE_PCT) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
  endtask

  // Fresh working set; some entries share x and y with their neighbor
  function automatic void build_pool(int size);
    int i;
    pool_size = size;
    for (i = 0; i < size; i++) begin
      if (i > 0 && $urandom_range(9) < 3) begin
        pool_x[i] = pool_x[i-1];
        pool_y[i] = pool_y[i-1];
      end else begin
        pool_x[i] = coord_t'($urandom);
        pool_y[i] = coord_t'($urandom);
      end
      pool_z[i] = coord_t'($urandom);
    end
  endfunction

  // Mostly working-set lookups (hot entries favored), some near misses, some noise
  function automatic chunk_request_t pick_request();
    chunk_request_t req;
    int idx;
    int sel;
    int b;
    sel = $urandom_range(99);
    if ($urandom_range(1) == 1) idx = $urandom_range((pool_size < 8 ? pool_size : 8) - 1);
    else idx = $urandom_range(pool_size - 1);
    req = make_request(pool_x[idx], pool_y[idx], pool_z[idx], $urandom_range(9) != 0);
    if (sel >= 70 && sel < 85) begin
      b = $urandom_range(FIELD_BITS - 1);
      case ($urandom_range(2))
        0: req.x[b] = ~req.x[b];
        1: req.y[b] = ~req.y[b];
        default: req.z[b] = ~req.z[b];
      endcase
      req.present = 1'($urandom_range(1));
    end else if (sel >= 85) begin
      req = make_request(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                         1'($urandom_range(1)));
    end
    return req;
  endfunction

  initial begin : stimulus
    int ph;
    int n;
    int pool_sizes [PHASES];
    pool_sizes = '{24, 40, 33, 48};
    tracker    = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: absent on an empty cache, extremes, hits, near misses
    offer_request(make_request(24'h000000, 24'h000000, 24'h000000, 1'b0));
    offer_request(make_request(24'h000000, 24'h000000, 24'h000000, 1'b1));
    offer_request(make_request(24'h000000, 24'h000000, 24'h000000, 1'b0));
    offer_request(make_request(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1));
    offer_request(make_request(24'h800000, 24'h800000, 24'h800000, 1'b1));
    offer_request(make_request(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1));
    offer_request(make_request(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFE, 1'b0));
    offer_request(make_request(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0));
    offer_request(make_request(24'h000001, 24'h000000, 24'h000000, 1'b1));
    offer_request(make_request(24'h000000, 24'h000001, 24'h000000, 1'b1));
    offer_request(make_request(24'h000000, 24'h000000, 24'h000001, 1'b1));
    offer_request(make_request(24'h000000, 24'h000000, 24'h000000, 1'b1));
    offer_request(make_request(24'h800000, 24'h7FFFFF, 24'h000000, 1'b0));
    offer_request(make_request(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1));
    offer_request(make_request(24'h800000, 24'h800000, 24'h800000, 1'b0));

    // Random phases; the third runs with no idling, holds land in two others
    for (ph = 0; ph < PHASES; ph++) begin
      build_pool(pool_sizes[ph]);
      calm = (ph == 2);
      if (ph == 1 || ph == 3) hold_request = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) offer_request(pick_request());
    end
    s_tvalid <= 1'b0;
    calm = 1'b0;

    // let the last accepted item be noted, then drain
    @(posedge clk);
    while (tracker.owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0)
      $display("chunk_cache_lru_lookup_test passed");
    else
      $display("chunk_cache_lru_lookup_test failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ccl_pkg.sv
rtl/ccl_ctrl.sv
rtl/ccl_datapath.sv
rtl/chunk_cache_lru_lookup.sv
test/chunk_cache_lru_lookup_test.sv
